### rtl/core/assert_macros.svh
// assertion helpers shared by the rtl, clocked on aclk and quiet in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising edge, disabled while aresetn is low
`define SCA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// implication whose consequent is checked on the following clock
`define SCA_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/core/sca_pkg.sv
`timescale 1ns / 1ps

package sca_pkg;

    localparam logic [7:0] SYNC_BYTE         = 8'haa;
    localparam logic [7:0] CMD_TYPE_BYTE     = 8'h55;
    localparam logic [3:0] DATA_TYPE_NIBBLE  = 4'hc;
    localparam int         CMD_FRAME_BYTES   = 20;
    localparam int         CMD_LAST_SUM_POS  = 18;
    localparam int         DATA_LEN_BIAS     = 5;
    localparam int         MAX_FRAME_BYTES   = 32;
    localparam int         COUNT_W           = 6;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_COMMAND = 2'd1,
        KIND_DATA    = 2'd2,
        KIND_UNKNOWN = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_MORE      = 3'd0,
        ST_GOOD      = 3'd1,
        ST_CSUM_BAD  = 3'd2,
        ST_SYNC_SKIP = 3'd3,
        ST_UNKNOWN   = 3'd4,
        ST_OVERFLOW  = 3'd5
    } status_t;

    function automatic kind_t kind_of(input logic [7:0] t);
        kind_t k;
        if (t == CMD_TYPE_BYTE) begin
            k = KIND_COMMAND;
        end else if (t[7:4] == DATA_TYPE_NIBBLE) begin
            k = KIND_DATA;
        end else begin
            k = KIND_UNKNOWN;
        end
        return k;
    endfunction

endpackage

### rtl/core/serial_can_adapter_deframer.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Serial CAN adapter deframer: one received serial byte goes in per word and
// one word comes out per byte, carrying the byte back with its position in
// the frame, the frame kind (tuser), a frame-end mark (tlast), the status and
// the total frame length on the closing byte. A frame opens with 0xaa; 0x55
// as second byte gives a 20-byte command frame whose last byte is checked
// against the 8-bit sum of bytes 2 to 18, a second byte 0xc? gives a data
// frame of low nibble + 5 bytes, anything else closes a two-byte unknown
// frame, and a byte that does not open a frame is reported as a skip. The
// block takes one byte every clock cycle: each byte is held in an input
// register, the frame tracking is a single combinational step into the
// output register, and only m_tready backpressure slows it down.
module serial_can_adapter_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // byte_echo[7:0], byte_position[12:8],
                                   // frame_status[15:13], frame_length[21:16], zero
    output logic        m_tlast,   // frame_end
    output logic [1:0]  m_tuser    // frame_kind
);

    localparam int CW = sca_pkg::COUNT_W;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // frame state
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    sum_reg, sum_next;

    // output register
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic [4:0]       out_pos_reg;
    sca_pkg::kind_t   out_kind_reg;
    logic             out_end_reg;
    sca_pkg::status_t out_status_reg;
    logic [CW-1:0]    out_len_reg;

    logic advance;
    logic in_take;

    sca_pkg::kind_t   kind_c;
    sca_pkg::kind_t   type_kind;
    sca_pkg::status_t status_c;
    logic             end_c;
    logic [CW-1:0]    len_c;
    logic [CW:0]      count_inc;
    logic [4:0]       data_need;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign count_inc = {1'b0, count_reg} + (CW+1)'(1);
    assign type_kind = sca_pkg::kind_of(type_reg);
    assign data_need = {1'b0, type_reg[3:0]} + 5'(sca_pkg::DATA_LEN_BIAS);

    always_comb begin
        kind_c     = sca_pkg::KIND_NONE;
        status_c   = sca_pkg::ST_MORE;
        end_c      = 1'b0;
        len_c      = '0;
        type_next  = type_reg;
        sum_next   = sum_reg;
        if (count_reg >= CW'(sca_pkg::MAX_FRAME_BYTES)) begin
            kind_c   = (count_reg >= CW'(2)) ? type_kind : sca_pkg::KIND_NONE;
            end_c    = 1'b1;
            status_c = sca_pkg::ST_OVERFLOW;
            len_c    = count_reg;
        end else if (count_reg == '0) begin
            if (in_byte_reg != sca_pkg::SYNC_BYTE) begin
                end_c    = 1'b1;
                status_c = sca_pkg::ST_SYNC_SKIP;
                len_c    = CW'(1);
            end
        end else if (count_reg == CW'(1)) begin
            type_next = in_byte_reg;
            kind_c    = sca_pkg::kind_of(in_byte_reg);
            if (kind_c == sca_pkg::KIND_UNKNOWN) begin
                end_c    = 1'b1;
                status_c = sca_pkg::ST_UNKNOWN;
                len_c    = CW'(2);
            end
        end else begin
            kind_c = type_kind;
            unique case (type_kind)
                sca_pkg::KIND_COMMAND: begin
                    if (count_reg <= CW'(sca_pkg::CMD_LAST_SUM_POS)) begin
                        sum_next = sum_reg + in_byte_reg;
                    end
                    if (count_inc >= (CW+1)'(sca_pkg::CMD_FRAME_BYTES)) begin
                        end_c    = 1'b1;
                        // the closing byte is past the summed range, so compare the held sum
                        status_c = (sum_reg == in_byte_reg) ? sca_pkg::ST_GOOD
                                                            : sca_pkg::ST_CSUM_BAD;
                        len_c    = CW'(sca_pkg::CMD_FRAME_BYTES);
                    end
                end
                sca_pkg::KIND_DATA: begin
                    if (count_inc >= (CW+1)'(data_need)) begin
                        end_c    = 1'b1;
                        status_c = sca_pkg::ST_GOOD;
                        len_c    = count_inc[CW-1:0];
                    end
                end
                default: begin
                    end_c    = 1'b1;
                    status_c = sca_pkg::ST_UNKNOWN;
                    len_c    = count_inc[CW-1:0];
                end
            endcase
        end
        count_next = end_c ? '0 : count_inc[CW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            type_reg      <= '0;
            sum_reg       <= '0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_tdata;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                out_byte_reg   <= in_byte_reg;
                out_pos_reg    <= count_reg[4:0];
                out_kind_reg   <= kind_c;
                out_end_reg    <= end_c;
                out_status_reg <= status_c;
                out_len_reg    <= len_c;
                count_reg      <= count_next;
                type_reg       <= end_c ? 8'h00 : type_next;
                sum_reg        <= end_c ? 8'h00 : sum_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_len_reg, out_status_reg, out_pos_reg, out_byte_reg};
    assign m_tlast  = out_end_reg;
    assign m_tuser  = out_kind_reg;

    // every frame closes by its twentieth byte
    `SCA_ASSERT(a_count_bound, count_reg < CW'(sca_pkg::CMD_FRAME_BYTES), "frame count overran")
    `SCA_ASSERT(a_last_has_status, !(out_valid_reg && out_end_reg) || out_status_reg != sca_pkg::ST_MORE, "closing word without status")
    `SCA_ASSERT(a_mid_no_length, !(out_valid_reg && !out_end_reg) || (out_len_reg == '0 && out_status_reg == sca_pkg::ST_MORE), "open word carries end info")
    `SCA_ASSERT_NEXT(a_end_clears, advance && end_c, count_reg == '0 && sum_reg == 8'h00, "state not cleared after frame end")
    `SCA_ASSERT_NEXT(a_pos_follows, advance && !end_c, out_pos_reg == $past(count_reg[4:0]) && count_reg == $past(count_reg) + CW'(1), "position did not step")

endmodule
